// ===== rtl/hjdd_pkg.sv =====
// Shared types and constants for the headset jack detect and button debounce block.
package hjdd_pkg;

  // Width of the debounce and phase timers.
  localparam int TIMER_BITS = 16;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_INDEX_BITS = 3;
  localparam int IN_DATA_BITS = 8;
  localparam int OUT_DATA_BITS = 8;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_PLUG_LEVEL      = 3'd0,
    REG_DETECT_DEBOUNCE = 3'd1,
    REG_BUTTON_DEBOUNCE = 3'd2,
    REG_BIAS_SETTLE     = 3'd3,
    REG_CLASSIFY        = 3'd4
  } hjdd_reg_t;

  // Insertion sequence phase.
  typedef enum logic [1:0] {
    PHASE_IDLE     = 2'd0,
    PHASE_SETTLE   = 2'd1,
    PHASE_CLASSIFY = 2'd2
  } hjdd_phase_t;

  // Configuration register contents.
  typedef struct packed {
    logic                  plug_in_level;
    logic [TIMER_BITS-1:0] detect_debounce_ticks;
    logic [TIMER_BITS-1:0] button_debounce_ticks;
    logic [TIMER_BITS-1:0] bias_settle_ticks;
    logic [TIMER_BITS-1:0] classify_ticks;
  } hjdd_cfg_t;

  // Plug level write notice toward the core.
  typedef struct packed {
    logic wr;
    logic level;
  } hjdd_plug_wr_t;

  // One result item.
  typedef struct packed {
    logic key_changed;
    logic key_down;
    logic mic_bias_on;
    logic headphone_only;
    logic accessory_present;
  } hjdd_result_t;

endpackage

// ===== rtl/hjdd_cfg_regs.sv =====
// Configuration register file of the headset jack detect block.
module hjdd_cfg_regs
  import hjdd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      wr_en,
  input  logic [CFG_INDEX_BITS-1:0] wr_index,
  input  logic [CFG_DATA_BITS-1:0]  wr_data,
  output hjdd_cfg_t                 cfg,
  output hjdd_plug_wr_t             plug_wr
);

  hjdd_cfg_t cfg_r;

  // Register writes; an index beyond the list is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.plug_in_level         <= 1'b0;
      cfg_r.detect_debounce_ticks <= TIMER_BITS'(500);
      cfg_r.button_debounce_ticks <= TIMER_BITS'(80);
      cfg_r.bias_settle_ticks     <= TIMER_BITS'(100);
      cfg_r.classify_ticks        <= TIMER_BITS'(500);
    end else if (wr_en) begin
      case (hjdd_reg_t'(wr_index))
        REG_PLUG_LEVEL:      cfg_r.plug_in_level         <= wr_data[0];
        REG_DETECT_DEBOUNCE: cfg_r.detect_debounce_ticks <= TIMER_BITS'(wr_data);
        REG_BUTTON_DEBOUNCE: cfg_r.button_debounce_ticks <= TIMER_BITS'(wr_data);
        REG_BIAS_SETTLE:     cfg_r.bias_settle_ticks     <= TIMER_BITS'(wr_data);
        REG_CLASSIFY:        cfg_r.classify_ticks        <= TIMER_BITS'(wr_data);
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

  // A plug level write also reloads the previous detect sample in the core.
  assign plug_wr.wr    = wr_en && (hjdd_reg_t'(wr_index) == REG_PLUG_LEVEL);
  assign plug_wr.level = wr_data[0];

endmodule

// ===== rtl/hjdd_core.sv =====
// Per-tick detect, insertion and button debounce state update.
module hjdd_core
  import hjdd_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic          detect_pin,
  input  logic          button_pin,
  input  hjdd_cfg_t     cfg,
  input  hjdd_plug_wr_t plug_wr,
  output hjdd_result_t  result
);

  logic                  present_r, present_nxt;
  logic                  headphone_r, headphone_nxt;
  logic                  key_r, key_nxt;
  logic                  ignore_r, ignore_nxt;
  logic                  btn_en_r, btn_en_nxt;
  logic                  bias_r, bias_nxt;
  logic [TIMER_BITS-1:0] det_tmr_r, det_tmr_nxt;
  logic                  det_run_r, det_run_nxt;
  logic                  det_pend_r, det_pend_nxt;
  logic [TIMER_BITS-1:0] btn_tmr_r, btn_tmr_nxt;
  logic                  btn_run_r, btn_run_nxt;
  hjdd_phase_t           phase_r, phase_nxt;
  logic [TIMER_BITS-1:0] phase_tmr_r, phase_tmr_nxt;
  logic                  last_det_r, last_det_nxt;
  logic                  last_btn_r, last_btn_nxt;

  // Next state for one tick, in the order the checks take effect.
  always_comb begin
    logic det_edge;
    logic qualifies;
    logic plugged;

    present_nxt   = present_r;
    headphone_nxt = headphone_r;
    key_nxt       = key_r;
    ignore_nxt    = ignore_r;
    btn_en_nxt    = btn_en_r;
    bias_nxt      = bias_r;
    det_tmr_nxt   = det_tmr_r;
    det_run_nxt   = det_run_r;
    det_pend_nxt  = det_pend_r;
    btn_tmr_nxt   = btn_tmr_r;
    btn_run_nxt   = btn_run_r;
    phase_nxt     = phase_r;
    phase_tmr_nxt = phase_tmr_r;
    last_det_nxt  = detect_pin;
    last_btn_nxt  = button_pin;

    plugged   = (detect_pin == cfg.plug_in_level);
    qualifies = present_r ? !plugged : plugged;
    det_edge  = (detect_pin != last_det_r) && qualifies;

    // Detect debounce: a qualifying edge restarts the timer.
    if (det_edge) begin
      if (present_r) begin
        ignore_nxt = 1'b1;
      end
      det_tmr_nxt = cfg.detect_debounce_ticks;
      det_run_nxt = 1'b1;
    end else if (det_run_r && det_tmr_r != '0) begin
      det_tmr_nxt = det_tmr_r - TIMER_BITS'(1);
    end
    if (det_run_nxt && det_tmr_nxt == '0) begin
      det_run_nxt  = 1'b0;
      det_pend_nxt = 1'b1;
    end

    // Button debounce: edges count only while the button is enabled.
    if ((button_pin != last_btn_r) && btn_en_r) begin
      btn_tmr_nxt = cfg.button_debounce_ticks;
      btn_run_nxt = 1'b1;
    end else if (btn_run_r && btn_tmr_r != '0) begin
      btn_tmr_nxt = btn_tmr_r - TIMER_BITS'(1);
    end
    if (btn_run_nxt && btn_tmr_nxt == '0) begin
      btn_run_nxt = 1'b0;
      if (present_r) begin
        if (!button_pin) begin
          if (ignore_nxt) begin
            ignore_nxt = 1'b0;
          end else begin
            key_nxt = 1'b0;
          end
        end else if (!ignore_nxt) begin
          key_nxt = 1'b1;
        end
      end
    end

    // Insertion sequence: bias settle wait, then optional classify wait.
    if (phase_r != PHASE_IDLE) begin
      if (phase_tmr_r != '0) begin
        phase_tmr_nxt = phase_tmr_r - TIMER_BITS'(1);
      end
      if (phase_tmr_nxt == '0) begin
        case (phase_r)
          PHASE_SETTLE: begin
            ignore_nxt = button_pin;
            btn_en_nxt = 1'b1;
            phase_nxt  = PHASE_IDLE;
            if (plugged) begin
              present_nxt = 1'b1;
              if (button_pin) begin
                phase_nxt     = PHASE_CLASSIFY;
                phase_tmr_nxt = cfg.classify_ticks;
              end
            end
          end
          default: begin
            if (button_pin) begin
              bias_nxt      = 1'b0;
              headphone_nxt = 1'b1;
            end
            phase_nxt = PHASE_IDLE;
          end
        endcase
      end
    end

    // Detection check, held back while an insertion is in progress.
    if (phase_nxt == PHASE_IDLE && det_pend_nxt) begin
      det_pend_nxt = 1'b0;
      if (!plugged) begin
        if (present_nxt) begin
          present_nxt   = 1'b0;
          headphone_nxt = 1'b0;
          btn_en_nxt    = 1'b0;
          key_nxt       = 1'b0;
          bias_nxt      = 1'b0;
        end
      end else if (!present_nxt) begin
        bias_nxt      = 1'b1;
        phase_nxt     = PHASE_SETTLE;
        phase_tmr_nxt = cfg.bias_settle_ticks;
      end
    end
  end

  // Control state, updated once per accepted tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r   <= 1'b0;
      headphone_r <= 1'b0;
      key_r       <= 1'b0;
      ignore_r    <= 1'b0;
      btn_en_r    <= 1'b0;
      bias_r      <= 1'b0;
      det_tmr_r   <= '0;
      det_run_r   <= 1'b0;
      det_pend_r  <= 1'b0;
      btn_tmr_r   <= '0;
      btn_run_r   <= 1'b0;
      phase_r     <= PHASE_IDLE;
      phase_tmr_r <= '0;
      last_det_r  <= 1'b1;
      last_btn_r  <= 1'b0;
    end else if (accept) begin
      present_r   <= present_nxt;
      headphone_r <= headphone_nxt;
      key_r       <= key_nxt;
      ignore_r    <= ignore_nxt;
      btn_en_r    <= btn_en_nxt;
      bias_r      <= bias_nxt;
      det_tmr_r   <= det_tmr_nxt;
      det_run_r   <= det_run_nxt;
      det_pend_r  <= det_pend_nxt;
      btn_tmr_r   <= btn_tmr_nxt;
      btn_run_r   <= btn_run_nxt;
      phase_r     <= phase_nxt;
      phase_tmr_r <= phase_tmr_nxt;
      last_det_r  <= last_det_nxt;
      last_btn_r  <= last_btn_nxt;
    end else if (plug_wr.wr) begin
      last_det_r  <= ~plug_wr.level;
    end
  end

  // Result of this tick, taken into the output register by the top level.
  assign result.accessory_present = present_nxt;
  assign result.headphone_only    = headphone_nxt;
  assign result.mic_bias_on       = bias_nxt;
  assign result.key_down          = key_nxt;
  assign result.key_changed       = key_nxt != key_r;

endmodule

// ===== rtl/headset_jack_detect_debounce.sv =====
// Top level of the headset jack detect and hook button debounce block.
//
// Usage: one request on the in_ channel per millisecond tick carries the
// sampled detect and hook button pins. Every request yields exactly one
// request on the out_ channel with the reported presence, headphone class,
// mic bias drive, media key level and a key change flag for that tick.
// out_tvalid rises in the cycle after input acceptance. Throughput is one
// tick per cycle while out_tready stays high: the whole per-tick update is a
// few timer compares and decrements between the state and output registers.
// The output register lets a new tick be taken in the same cycle that the
// waiting result is taken; while the receiver holds out_tready low with a
// result waiting, in_tready drops and the state does not advance.
// Configuration writes go through the cfg_ port, always ready, and must be made
// only while no tick is in flight; the block does not enforce this. Writing the
// plug level also reloads the previous detect sample with its inverse.
// Reset (rst_n low, synchronous) restores the default tick counts, clears all
// detect, insertion and button state and empties the output register.
module headset_jack_detect_debounce
  import hjdd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  // Input ticks.
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [IN_DATA_BITS-1:0]   in_tdata,   // [0] detect_pin, [1] button_pin
  // Results.
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // [0] accessory_present, [1] headphone_only, [2] mic_bias_on, [3] key_down,
  // [4] key_changed
  output logic [OUT_DATA_BITS-1:0]  out_tdata,
  // Configuration writes.
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  hjdd_cfg_t     cfg;
  hjdd_plug_wr_t plug_wr;
  hjdd_result_t  result;
  hjdd_result_t  out_data_r;
  logic          out_valid_r, out_valid_nxt;
  logic          accept;

  assign cfg_ready = 1'b1;

  hjdd_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg),
    .plug_wr  (plug_wr)
  );

  // Accept a tick whenever the output register is empty or being drained.
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  hjdd_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .detect_pin (in_tdata[0]),
    .button_pin (in_tdata[1]),
    .cfg        (cfg),
    .plug_wr    (plug_wr),
    .result     (result)
  );

  // Output register valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_BITS - $bits(hjdd_result_t)){1'b0}}, out_data_r};

`ifndef NO_ASSERTIONS
  // A headphone class is only ever reported for a present accessory.
  a_hp_needs_present: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |-> out_tdata[0])
    else $error("headphone_only reported without accessory_present");

  // The media key is held down only while an accessory is present.
  a_key_needs_present: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3] |-> out_tdata[0])
    else $error("key_down reported without accessory_present");

  // An accepted tick always shows up as a result in the next cycle.
  a_accept_to_valid: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted tick produced no result");
`endif

endmodule
